// ===== rtl/tdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared types and constants of the trial-division prime counter
// ----------------------------------------------------------------------------
`default_nettype none

package tdpc_pkg;

    // width of the candidate port and of the running count
    localparam int unsigned CAND_W  = 32;
    localparam int unsigned COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_START = 2'd1,
        ST_WAIT  = 2'd2,
        ST_EMIT  = 2'd3
    } tdpc_state_t;

endpackage

`default_nettype wire

// ===== rtl/tdpc_divider.sv =====
// ----------------------------------------------------------------------------
// tdpc_divider
// restoring divider, one quotient bit per cycle, gives quotient and remainder
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_divider #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic      [WIDTH-1:0] quotient,
    output logic      [WIDTH-1:0] remainder,
    output logic                  done
);

    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   trial;
    logic             fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        trial     = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit in, subtract when it fits
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? trial[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ===== rtl/trial_division_prime_counter.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_counter
// primality test by trial division with a saturating running prime count
// ----------------------------------------------------------------------------
//  channel  | ports                               | carries
//  ---------+-------------------------------------+-------------------------------
//  input    | s_valid s_ready s_candidate[31:0]   | one candidate word
//  result   | m_valid m_ready m_is_prime          | verdict and running prime
//           | m_primes_found[31:0]                | count, one word per input
//
//  one candidate at a time; s_ready is high only while the sequencer is idle
//  zero, one, two and even words go from idle straight to ST_EMIT; an odd
//  word n runs one division per odd divisor tried, up to about floor(sqrt(n)) / 2
//  divisors, on the shared one-bit-per-cycle divider (NW = min(VALUE_WIDTH, 32))
//  a finished verdict waits in ST_EMIT while the result register is stalled
//  aresetn (synchronous) clears the sequencer, the result valid and the count
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_counter #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tdpc_pkg::CAND_W-1:0]  s_candidate,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_is_prime,
    output logic      [tdpc_pkg::COUNT_W-1:0] m_primes_found
);

    // width actually tested: the candidate port is only 32 bits wide
    localparam int unsigned NW = (VALUE_WIDTH < tdpc_pkg::CAND_W) ?
                                 VALUE_WIDTH : tdpc_pkg::CAND_W;

    tdpc_pkg::tdpc_state_t state_reg, state_next;

    logic [NW-1:0]                n_reg, n_next;       // value under test
    logic [NW-1:0]                d_reg, d_next;       // current odd divisor
    logic                         prime_reg, prime_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_is_prime_reg, m_is_prime_next;
    logic [tdpc_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [NW-1:0] cand;
    logic          div_start;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_rem;
    logic          div_done;

    assign cand = s_candidate[NW-1:0];

    // shared divider: n / d and n % d for each trial divisor
    tdpc_divider #(
        .WIDTH (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        prime_next      = prime_reg;
        m_valid_next    = m_valid_reg;
        m_is_prime_next = m_is_prime_reg;
        count_next      = count_reg;
        div_start       = 1'b0;
        s_ready         = 1'b0;

        // the consumer drains the result register independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tdpc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    n_next = cand;
                    d_next = NW'(3);
                    if (cand[NW-1:1] == '0) begin
                        // zero or one: not prime
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_EMIT;
                    end else if (cand == NW'(2)) begin
                        prime_next = 1'b1;
                        state_next = tdpc_pkg::ST_EMIT;
                    end else if (!cand[0]) begin
                        // even above two
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_EMIT;
                    end else begin
                        state_next = tdpc_pkg::ST_START;
                    end
                end
            end
            tdpc_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = tdpc_pkg::ST_WAIT;
            end
            tdpc_pkg::ST_WAIT: begin
                if (div_done) begin
                    if (d_reg > div_quo) begin
                        // d*d > n: no divisor left, prime
                        prime_next = 1'b1;
                        state_next = tdpc_pkg::ST_EMIT;
                    end else if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_EMIT;
                    end else begin
                        // d <= n/3 here, so d + 2 cannot wrap
                        d_next     = d_reg + NW'(2);
                        state_next = tdpc_pkg::ST_START;
                    end
                end
            end
            tdpc_pkg::ST_EMIT: begin
                // load the result register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_is_prime_next = prime_reg;
                    if (prime_reg && (count_reg != tdpc_pkg::COUNT_MAX)) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = tdpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        d_reg          <= d_next;
        prime_reg      <= prime_next;
        m_is_prime_reg <= m_is_prime_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_is_prime     = m_is_prime_reg;
    assign m_primes_found = count_reg;

endmodule

`default_nettype wire

// ===== rtl/tdpc_checker.sv =====
// ----------------------------------------------------------------------------
// tdpc_checker
// port-level checks of the prime counter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic [tdpc_pkg::CAND_W-1:0]  s_candidate,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_is_prime,
    input wire logic [tdpc_pkg::COUNT_W-1:0] m_primes_found
);

    // a waiting candidate word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_candidate))
        else $error("candidate word changed while waiting");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime) && $stable(m_primes_found))
        else $error("result word changed while stalled");

    // one word in flight: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is being tested");

    // the count only moves together with a prime verdict
    a_count_on_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(m_primes_found) |-> m_valid && m_is_prime)
        else $error("count changed without a prime verdict");

    // the count steps by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(m_primes_found) |->
            m_primes_found == ($past(m_primes_found) + 32'd1))
        else $error("count did not step by one");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_candidate    (s_candidate),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_is_prime     (m_is_prime),
    .m_primes_found (m_primes_found)
);

`default_nettype wire

// ===== tb/trial_division_prime_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_counter_test
// self-checking bench: candidate words in, verdict and running count out
// ----------------------------------------------------------------------------
// A short table of hand-picked candidates comes first, then random words.
// Every accepted candidate goes through a trial-division model kept in the
// bench, which also keeps its own saturating prime tally. Each result word is
// compared field by field with the oldest expectation. Both channels idle at
// random, and once the result side holds off for a long stretch so that the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_counter_test;

    localparam int unsigned RANDOM_ITEMS = 76;
    localparam int unsigned HOLD_CYCLES  = 400;    // long result-side hold-off
    localparam int unsigned HOLD_AFTER   = 30;     // results taken before the hold
    localparam int unsigned DRAIN_CYCLES = 200;    // quiet time after the last result
    // the slowest legal run has two 24-bit candidates at about 2048 divisors
    // each, random words capped near 128 divisors and all gaps at their
    // longest; the watchdog limit leaves ample margin over it
    localparam int unsigned LIMIT_CYCLES = 2_500_000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned WIDE_TRIALS  = 64;     // divisor budget for wide random words

    // one expected result word
    typedef struct packed {
        logic                         is_prime;
        logic [tdpc_pkg::COUNT_W-1:0] primes_found;
    } verdict_t;

    // one row of the directed table; pinned rows carry the result typed in
    typedef struct packed {
        logic [tdpc_pkg::CAND_W-1:0]  candidate;
        logic                         pinned;
        logic                         is_prime;
        logic [tdpc_pkg::COUNT_W-1:0] primes_found;
    } directed_row_t;

    localparam int unsigned DIRECTED_ROWS = 24;

    // pinned rows are the ones readable at a glance: reset value, small
    // numbers and the extremes of the field, all of which settle fast
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{32'd0,          1'b1, 1'b0, 32'd0},   // zero straight after reset
        '{32'd1,          1'b1, 1'b0, 32'd0},   // one is not prime
        '{32'd2,          1'b1, 1'b1, 32'd1},   // two is the only even prime
        '{32'd3,          1'b1, 1'b1, 32'd2},   // divisor loop never runs
        '{32'd4,          1'b1, 1'b0, 32'd2},   // smallest even composite
        '{32'hFFFF_FFFE,  1'b1, 1'b0, 32'd2},   // largest even word
        '{32'hFFFF_FFFF,  1'b1, 1'b0, 32'd2},   // all ones, divisible by three
        '{32'h8000_0000,  1'b1, 1'b0, 32'd2},   // top bit alone
        '{32'd5,          1'b0, 1'b0, 32'd0},
        '{32'd9,          1'b0, 1'b0, 32'd0},   // divisor squared equals the word
        '{32'd25,         1'b0, 1'b0, 32'd0},
        '{32'd49,         1'b0, 1'b0, 32'd0},
        '{32'd15,         1'b0, 1'b0, 32'd0},
        '{32'd97,         1'b0, 1'b0, 32'd0},
        '{32'd121,        1'b0, 1'b0, 32'd0},
        '{32'h8000_0001,  1'b0, 1'b0, 32'd0},
        '{32'h5555_5555,  1'b0, 1'b0, 32'd0},
        '{32'hAAAA_AAAB,  1'b0, 1'b0, 32'd0},
        '{32'd65521,      1'b0, 1'b0, 32'd0},   // largest 16-bit prime
        '{32'd65535,      1'b0, 1'b0, 32'd0},
        '{32'd16752649,   1'b0, 1'b0, 32'd0},   // square of the prime 4093
        '{32'd16777213,   1'b0, 1'b0, 32'd0},   // largest prime below 2^24
        '{32'd0,          1'b0, 1'b0, 32'd0},   // zero again: count must hold
        '{32'd1,          1'b0, 1'b0, 32'd0}
    };

    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [tdpc_pkg::CAND_W-1:0]  s_candidate    = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic                         m_is_prime;
    logic [tdpc_pkg::COUNT_W-1:0] m_primes_found;

    // side fields that travel with the word on the input channel
    logic                         word_pinned    = 1'b0;
    logic                         pinned_prime   = 1'b0;
    logic [tdpc_pkg::COUNT_W-1:0] pinned_count   = '0;

    verdict_t                     awaited_verdicts [$];
    logic [tdpc_pkg::COUNT_W-1:0] prime_tally    = '0;
    int unsigned                  failures       = 0;
    int unsigned                  cycle_count    = 0;
    int unsigned                  sender_steady  = 0;
    int unsigned                  receiver_steady = 0;

    trial_division_prime_counter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_candidate    (s_candidate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_prime     (m_is_prime),
        .m_primes_found (m_primes_found)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // trial division by odd divisors while d <= n / d; trials counts the
    // divisors tried, which is roughly what the block spends in its divider
    function automatic logic trial_divide(input logic [tdpc_pkg::CAND_W-1:0] n,
                                          output int unsigned trials);
        logic [tdpc_pkg::CAND_W-1:0] d;
        trials = 0;
        if (n <= 1)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            trials++;
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // idle length for one side: mostly none or short, now and then long,
    // and from time to time a run of back-to-back words
    function automatic int unsigned idle_cycles(inout int unsigned steady_left);
        int unsigned r;
        if (steady_left != 0) begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady_left = $urandom_range(8, 24);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // half small words, some 16-bit ones, the rest full-width; a full-width
    // word that would need many divisors, or is a large prime, is made even, so
    // bit 0 of wide words is set only when cheap
    function automatic logic [tdpc_pkg::CAND_W-1:0] random_candidate();
        logic [tdpc_pkg::CAND_W-1:0] n;
        int unsigned                 pick;
        int unsigned                 trials;
        logic                        verdict;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            n = $urandom_range(0, 4095);
        end else if (pick < 7) begin
            n = $urandom_range(0, 65535);
        end else begin
            n = $urandom;
            verdict = trial_divide(n, trials);
            if (trials > WIDE_TRIALS || (verdict && n > 65535))
                n[0] = 1'b0;
        end
        return n;
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // put one word on the input channel after a random gap and wait for it
    // to be taken; valid is only dropped when a gap follows
    task automatic offer_word(input logic [tdpc_pkg::CAND_W-1:0] cand,
                              input logic pinned, input logic t_prime,
                              input logic [tdpc_pkg::COUNT_W-1:0] t_count);
        int unsigned gap;
        gap = idle_cycles(sender_steady);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_candidate  <= cand;
        word_pinned  <= pinned;
        pinned_prime <= t_prime;
        pinned_count <= t_count;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // every accepted candidate is run through the bench model; pinned rows
    // still advance the tally but their expectation is the typed-in one
    always @(posedge aclk) begin : candidate_accept
        logic        verdict;
        int unsigned trials;
        if (aresetn && s_valid && s_ready) begin
            verdict = trial_divide(s_candidate, trials);
            if (verdict && prime_tally != tdpc_pkg::COUNT_MAX)
                prime_tally = prime_tally + 1'b1;
            if (word_pinned)
                awaited_verdicts.push_back('{pinned_prime, pinned_count});
            else
                awaited_verdicts.push_back('{verdict, prime_tally});
        end
    end

    // result side: each word taken is checked against the oldest expectation
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_verdicts.size() == 0) begin
                note_failure($sformatf(
                    "result word with nothing awaited (is_prime %0b, count %0d)",
                    m_is_prime, m_primes_found));
            end else begin
                want = awaited_verdicts.pop_front();
                if (m_is_prime !== want.is_prime)
                    note_failure($sformatf("is_prime expected %0b got %0b",
                                           want.is_prime, m_is_prime));
                if (m_primes_found !== want.primes_found)
                    note_failure($sformatf("primes_found expected %0d got %0d",
                                           want.primes_found, m_primes_found));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result consumer: random stalls, plus one long hold-off while the
    // sender keeps offering, so the block sits with a finished verdict
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        logic        held;
        taken = 0;
        held  = 1'b0;
        forever begin
            if (!held && taken == HOLD_AFTER) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_cycles(receiver_steady);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn === 1'b1 && m_valid === 1'b1));
            taken++;
        end
    end

    initial begin : stimulus
        int unsigned row;
        // reset held low from the start, released on a rising edge
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_word(directed_rows[row].candidate, directed_rows[row].pinned,
                       directed_rows[row].is_prime, directed_rows[row].primes_found);

        // the count cannot be driven to saturation from the port in any
        // sensible run time; the bench model still saturates
        repeat (RANDOM_ITEMS)
            offer_word(random_candidate(), 1'b0, 1'b0, '0);
        s_valid <= 1'b0;

        while (awaited_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0 && awaited_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
